// File: rtl/bounded_ordered_list_macros.svh
// ----------------------------------------------------------------------------
// bounded_ordered_list_macros: assertion helpers for the ordered list
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_MACROS_SVH
`define BOUNDED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication.
`define BOL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bounded_ordered_list: same-cycle check failed");

// Next-cycle implication.
`define BOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bounded_ordered_list: next-cycle check failed");

`endif

// File: rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared definitions of the bounded ordered list
// Depth, derived widths, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE    = 2'd2;
  localparam logic [OP_W-1:0] OP_READ      = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic ins_front;  // every cell takes its left neighbor's value
    logic ins_rear;   // the cell at the fill level takes the word value
    logic start;      // load match flag and read tap
    logic prop;       // pass match flag and read tap one cell right
    logic compact;    // cells at or after the hit take the right neighbor
  } bol_cell_ctrl_t;

endpackage

// File: rtl/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell: one storage cell of the ordered list
// Holds one entry, a sticky match flag and a read tap that ripple one cell a cycle.
// ----------------------------------------------------------------------------
module bol_cell import bol_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bol_cell_ctrl_t           ctrl_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [VAL_W-1:0]  key_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic signed [VAL_W-1:0]  prev_val_i,
  input  logic signed [VAL_W-1:0]  next_val_i,
  input  logic                     prev_kill_i,
  input  logic [VAL_W-1:0]         prev_pass_i,
  output logic signed [VAL_W-1:0]  val_o,
  output logic                     kill_o,
  output logic [VAL_W-1:0]         pass_o
);

  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    kill_q, kill_d;
  logic [VAL_W-1:0]        pass_q, pass_d;
  logic                    in_list;
  logic                    at_rear;
  logic                    pos_hit;
  logic [POS_W:0]          my_pos;

  assign in_list = CNT_W'(idx_i) < count_i;
  assign at_rear = CNT_W'(idx_i) == count_i;
  assign my_pos  = (POS_W+1)'(idx_i) + {{POS_W{1'b0}}, 1'b1};
  assign pos_hit = {1'b0, pos_i} == my_pos;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_front) begin
      val_d = prev_val_i;
    end else if (ctrl_i.ins_rear && at_rear) begin
      val_d = key_i;
    end else if (ctrl_i.compact && kill_q) begin
      val_d = next_val_i;
    end
  end

  always_comb begin
    kill_d = kill_q;
    pass_d = pass_q;
    if (ctrl_i.start) begin
      kill_d = in_list && (val_q == key_i);
      pass_d = pos_hit ? VAL_W'(val_q) : '0;
    end else if (ctrl_i.prop) begin
      kill_d = kill_q | prev_kill_i;
      pass_d = pass_q | prev_pass_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pass_q <= pass_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_q <= 1'b0;
    end else begin
      kill_q <= kill_d;
    end
  end

  assign val_o  = val_q;
  assign kill_o = kill_q;
  assign pass_o = pass_q;

endmodule

// File: rtl/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered list of up to DEPTH signed 32-bit entries
// Insert front/rear, delete first match, read by position; one result word each.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op_i, item_value_i, position_i
//   out      output     out_valid_o / out_ready_i status_o, read_value_o,
//                                                  entry_count_o
//
// Inserts and early-status words pass through S_FIN to the output register, and
// the input reopens once S_FIN has loaded it; delete and read first pass through
// S_SCAN, where the match flag and read tap ripple one cell per cycle down the
// chain of DEPTH cells, and then through S_FIN.
// A new word is accepted while the previous result waits on out_ready_i; its
// own result then holds until the output register frees up.
// Reset empties the list at once; entries are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_macros.svh"

module bounded_ordered_list import bol_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [VAL_W-1:0]  item_value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic [CNT_W-1:0]         entry_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

  logic [1:0]              state_q, state_d;
  logic [IDX_W-1:0]        step_q, step_d;
  logic                    del_q, del_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [STAT_W-1:0]       res_status_q, res_status_d;
  logic signed [VAL_W-1:0] res_value_q, res_value_d;
  logic                    out_valid_q, out_valid_d;
  logic [STAT_W-1:0]       out_status_q, out_status_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]        out_count_q, out_count_d;

  bol_cell_ctrl_t          ctrl;
  logic                    acc;
  logic                    is_ins;
  logic                    full;
  logic                    pos_ok;
  logic                    scan_done;

  logic signed [VAL_W-1:0] cell_val  [DEPTH];
  logic                    cell_kill [DEPTH];
  logic [VAL_W-1:0]        cell_pass [DEPTH];

  assign in_ready_o = state_q == S_IDLE;
  assign acc        = in_valid_i && in_ready_o;
  assign is_ins     = (op_i == OP_INS_FRONT) || (op_i == OP_INS_REAR);
  assign full       = count_q == CNT_W'(DEPTH);
  assign pos_ok     = (position_i != '0) &&
                      ({1'b0, position_i} <= (POS_W+1)'(count_q));
  assign scan_done  = (state_q == S_SCAN) && (step_q == LAST_STEP);

  always_comb begin
    ctrl.ins_front = acc && (op_i == OP_INS_FRONT) && !full;
    ctrl.ins_rear  = acc && (op_i == OP_INS_REAR) && !full;
    ctrl.start     = acc && !is_ins && (count_q != '0);
    ctrl.prop      = (state_q == S_SCAN) && (step_q != LAST_STEP);
    ctrl.compact   = scan_done && del_q && cell_kill[DEPTH-1];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] prev_val;
    logic signed [VAL_W-1:0] next_val;
    logic                    prev_kill;
    logic [VAL_W-1:0]        prev_pass;

    if (g == 0) begin : g_head
      assign prev_val  = item_value_i;
      assign prev_kill = 1'b0;
      assign prev_pass = '0;
    end else begin : g_body
      assign prev_val  = cell_val[g-1];
      assign prev_kill = cell_kill[g-1];
      assign prev_pass = cell_pass[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_val = cell_val[g];
    end else begin : g_inner
      assign next_val = cell_val[g+1];
    end

    bol_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .idx_i       (IDX_W'(g)),
      .count_i     (count_q),
      .key_i       (item_value_i),
      .pos_i       (position_i),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .prev_kill_i (prev_kill),
      .prev_pass_i (prev_pass),
      .val_o       (cell_val[g]),
      .kill_o      (cell_kill[g]),
      .pass_o      (cell_pass[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    del_d        = del_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_value_d = '0;
          state_d     = S_FIN;
          if (is_ins) begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              res_status_d = ST_OK;
              count_d      = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
          end else if ((op_i == OP_READ) && !pos_ok) begin
            res_status_d = ST_BAD_POS;
          end else begin
            state_d = S_SCAN;
            step_d  = '0;
            del_d   = op_i == OP_DELETE;
          end
        end
      end
      S_SCAN: begin
        if (step_q != LAST_STEP) begin
          step_d = step_q + 1'b1;
        end else begin
          step_d  = '0;
          state_d = S_FIN;
          if (del_q) begin
            res_value_d = '0;
            if (cell_kill[DEPTH-1]) begin
              res_status_d = ST_OK;
              count_d      = count_q - 1'b1;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end else begin
            res_status_d = ST_OK;
            res_value_d  = cell_pass[DEPTH-1];
          end
        end
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      del_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      del_q       <= del_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign entry_count_o = out_count_q;

  `BOL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `BOL_ASSERT_NOW(a_step_idle, state_q != S_SCAN, step_q == '0)
  `BOL_ASSERT_NEXT(a_full_hold, acc && is_ins && full, count_q == $past(count_q))
  `BOL_ASSERT_NEXT(a_ins_grow, acc && is_ins && !full, count_q == $past(count_q) + 1'b1)

endmodule

// File: dv/bounded_ordered_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_tb: self-checking bench for the bounded ordered list
// Drives insert, delete and read words through the valid/ready channels and
// tracks the list in a shadow queue. Each result word is checked against the
// oldest predicted result. Sender gaps, receiver stalls and a long output
// hold-off are applied.
// ----------------------------------------------------------------------------
module bounded_ordered_list_tb;
  import bol_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = DEPTH + 8;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i;
  logic signed [VAL_W-1:0]  item_value_i;
  logic [POS_W-1:0]         position_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STAT_W-1:0]        status_o;
  logic signed [VAL_W-1:0]  read_value_o;
  logic [CNT_W-1:0]         entry_count_o;

  logic signed [VAL_W-1:0] shadow_list[$];
  list_result_t            pending_results[$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  bounded_ordered_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .item_value_i  (item_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Apply one operation to the shadow list and return the result it yields.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic signed [VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    int           hit;
    res.status = ST_OK;
    res.value  = '0;
    hit        = -1;
    if (op == OP_INS_FRONT || op == OP_INS_REAR) begin
      if (shadow_list.size() >= DEPTH) res.status = ST_FULL;
      else if (op == OP_INS_FRONT) shadow_list.push_front(val);
      else shadow_list.push_back(val);
    end else if (shadow_list.size() == 0) begin
      res.status = ST_EMPTY;
    end else if (op == OP_DELETE) begin
      for (int i = 0; i < shadow_list.size(); i++) begin
        if (hit < 0 && shadow_list[i] === val) hit = i;
      end
      if (hit < 0) res.status = ST_NOT_FOUND;
      else shadow_list.delete(hit);
    end else begin
      if (pos == 0 || pos > shadow_list.size()) res.status = ST_BAD_POS;
      else res.value = shadow_list[pos - 1];
    end
    res.count = CNT_W'(shadow_list.size());
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return $urandom_range(7);
    if (r == 4) begin
      case ($urandom_range(3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly a key that is present, so deletes hit and the list drains.
  function automatic logic signed [VAL_W-1:0] pick_key();
    if (shadow_list.size() > 0 && $urandom_range(9) < 7)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(9) < 7) return POS_W'($urandom_range(shadow_list.size() + 1));
    return POS_W'($urandom_range(255));
  endfunction

  // Offer one word, hold it until accepted, then record its expected result.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    item_value_i <= val;
    position_i   <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_list_op(op, val, pos));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic check_result();
    list_result_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word, status %0d value %0d count %0d",
               $time, status_o, read_value_o, entry_count_o);
      error_count++;
      return;
    end
    exp = pending_results.pop_front();
    if (status_o !== exp.status) begin
      $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, status_o);
      error_count++;
    end
    if (read_value_o !== exp.value) begin
      $display("%0t: read_value mismatch, expected %0d, got %0d",
               $time, exp.value, read_value_o);
      error_count++;
    end
    if (entry_count_o !== exp.count) begin
      $display("%0t: entry_count mismatch, expected %0d, got %0d",
               $time, exp.count, entry_count_o);
      error_count++;
    end
  endtask

  // Output side: check accepted words, then pick ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_word(OP_READ, '0, 8'd1);
    send_word(OP_DELETE, 32'sd5, 8'd0);
    send_word(OP_INS_FRONT, VAL_MAX, 8'd0);
    send_word(OP_INS_REAR, VAL_MIN, 8'd0);
    send_word(OP_INS_FRONT, -1, 8'd0);
    send_word(OP_INS_REAR, -1, 8'd0);
    send_word(OP_READ, '0, 8'd0);
    send_word(OP_READ, '0, 8'd4);
    send_word(OP_READ, '0, 8'd5);
    send_word(OP_READ, VAL_MAX, 8'd255);
    send_word(OP_DELETE, '0, 8'd0);
    // duplicate key: only the front copy goes
    send_word(OP_DELETE, -1, 8'd0);
    send_word(OP_READ, '0, 8'd3);
    send_word(OP_DELETE, VAL_MIN, 8'd0);
    wait_idle();
  endtask

  task automatic test_fill_drain();
    sender_idle_pct = 14;
    recv_stall_pct  = 14;
    while (shadow_list.size() < DEPTH)
      send_word($urandom_range(1) ? OP_INS_FRONT : OP_INS_REAR, pick_value(), pick_position());
    send_word(OP_INS_FRONT, pick_value(), '0);
    send_word(OP_INS_REAR, pick_value(), '0);
    send_word(OP_READ, '0, POS_W'(DEPTH));
    send_word(OP_READ, '0, POS_W'(DEPTH + 1));
    while (shadow_list.size() > 0) send_word(OP_DELETE, pick_key(), pick_position());
    send_word(OP_READ, '0, 8'd1);
    wait_idle();
  endtask

  // Hold the output off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests++;
    for (int i = 0; i < 40; i++)
      send_word(OP_W'($urandom_range(3)), pick_value(), pick_position());
    wait_idle();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned sidle,
                             input int unsigned rstall);
    bit              filling;
    int unsigned     r;
    logic [OP_W-1:0] op;
    sender_idle_pct = sidle;
    recv_stall_pct  = rstall;
    filling         = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      // swing between filling and draining so both full and empty are hit
      if (i % 48 == 47) filling = !filling;
      r = $urandom_range(99);
      if (filling)
        op = (r < 35) ? OP_INS_FRONT : (r < 70) ? OP_INS_REAR : (r < 85) ? OP_DELETE : OP_READ;
      else
        op = (r < 8) ? OP_INS_FRONT : (r < 15) ? OP_INS_REAR : (r < 80) ? OP_DELETE : OP_READ;
      send_word(op, (op == OP_DELETE) ? pick_key() : pick_value(), pick_position());
    end
    wait_idle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_READ;
    item_value_i = '0;
    position_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_drain();
    test_backpressure();
    test_random(310, 0, 0);
    test_random(310, 61, 0);
    test_random(310, 0, 61);
    test_random(310, 14, 14);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/bol_pkg.sv
rtl/bol_cell.sv
rtl/bounded_ordered_list.sv
dv/bounded_ordered_list_tb.sv
